// ===== design/stdg_pkg.sv =====
package stdg_pkg;

  localparam int ELEMENT_BYTES_DEF = 4;
  localparam int DIM_WIDTH_DEF     = 16;

  localparam int OFS_W     = 48;
  localparam int BYTES_W   = 52;
  localparam int START_W   = 31;
  localparam int SAT_W     = OFS_W + 1;
  localparam int REG_IDX_W = 3;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = REG_IDX_W + 2;

  // saturated operand value, anything at or above 2^48
  localparam logic [SAT_W-1:0] SAT_CAP = SAT_W'(1) << OFS_W;

  localparam logic [REG_IDX_W-1:0] REG_START         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_STRIDE    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PLANE_ROWS    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BATCH_PLANES  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TILE_HEIGHT   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TILE_CHANNELS = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TILE_BATCHES  = 3'd7;

  localparam logic [1:0] MERGE_NONE    = 2'd0;
  localparam logic [1:0] MERGE_ROWS    = 2'd1;
  localparam logic [1:0] MERGE_PLANES  = 2'd2;
  localparam logic [1:0] MERGE_BATCHES = 2'd3;

  typedef enum logic [1:0] {
    STEP_OUTER,
    STEP_MIDDLE,
    STEP_INNER
  } stdg_step_t;

  typedef struct packed {
    logic restart;
    logic direction;
  } stdg_in_t;

  typedef struct packed {
    logic [OFS_W-1:0]   strided_offset;
    logic [OFS_W-1:0]   packed_offset;
    logic [OFS_W-1:0]   chunk_length;
    logic [BYTES_W-1:0] bytes_so_far;
    logic               direction_tag;
    logic               last_chunk;
    logic               overflow;
  } stdg_out_t;

  typedef struct packed {
    logic       accept;
    logic       restart;
    logic       mul_go;
    stdg_step_t step;
    logic       emit;
  } stdg_cmd_t;

  typedef struct packed {
    logic tile_ok;
    logic last;
  } stdg_status_t;

endpackage

// ===== design/stdg_mac.sv =====
module stdg_mac #(
  parameter int DIM_W = stdg_pkg::DIM_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [stdg_pkg::SAT_W-1:0] a,
  input  logic [DIM_W-1:0]           b,
  input  logic [stdg_pkg::SAT_W-1:0] addend,
  output logic [stdg_pkg::SAT_W-1:0] result
);
  import stdg_pkg::*;

  localparam int LO_W  = 32;
  localparam int HI_W  = SAT_W - LO_W;
  localparam int SUM_W = SAT_W + DIM_W + 1;

  logic                    go_r;
  logic [LO_W+DIM_W-1:0]   pp_lo_r;
  logic [HI_W+DIM_W-1:0]   pp_hi_r;
  logic [SAT_W-1:0]        add_r;
  logic [SAT_W-1:0]        result_r;
  logic [SUM_W-1:0]        sum;
  logic [SAT_W-1:0]        sat;

  // result = min(a * b + addend, 2^48)
  always_comb begin
    sum = (SUM_W'(pp_hi_r) << LO_W) + SUM_W'(pp_lo_r) + SUM_W'(add_r);
    sat = (|sum[SUM_W-1:OFS_W]) ? SAT_CAP : sum[SAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      pp_lo_r <= (LO_W+DIM_W)'(a[LO_W-1:0]) * (LO_W+DIM_W)'(b);
      pp_hi_r <= (HI_W+DIM_W)'(a[SAT_W-1:LO_W]) * (HI_W+DIM_W)'(b);
      add_r   <= addend;
    end
    if (go_r) begin
      result_r <= sat;
    end
  end

  assign result = result_r;

endmodule

// ===== design/stdg_datapath.sv =====
module stdg_datapath #(
  parameter int ELEMENT_BYTES = stdg_pkg::ELEMENT_BYTES_DEF,
  parameter int DIM_WIDTH     = stdg_pkg::DIM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [stdg_pkg::REG_IDX_W-1:0] cfg_idx,
  input  logic [stdg_pkg::APB_DW-1:0]    cfg_wdata,
  output logic [stdg_pkg::APB_DW-1:0]    cfg_rdata,
  input  logic                           in_direction,
  input  stdg_pkg::stdg_cmd_t            cmd,
  output stdg_pkg::stdg_status_t         status,
  output stdg_pkg::stdg_out_t            out_word
);
  import stdg_pkg::*;

  localparam int DW = DIM_WIDTH;

  logic [START_W-1:0] start_r;
  logic [DW-1:0]      ldw_r, ldh_r, ldc_r;
  logic [DW-1:0]      tw_r, th_r, tc_r, tn_r;

  logic [DW-1:0]      row_r, plane_r, batch_r;
  logic [DW-1:0]      row_nxt, plane_nxt, batch_nxt;
  logic [OFS_W-1:0]   packed_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [1:0]         merge_r;
  logic               dir_r;
  stdg_out_t          out_r;

  logic [1:0]         merge_calc;
  logic [SAT_W-1:0]   off_a, off_add, len_a;
  logic [DW-1:0]      off_b, len_b;
  logic [SAT_W-1:0]   off_res, len_res;

  logic               soff_ovf, len_ovf, pk_ovf;
  logic [OFS_W-1:0]   soff, len;
  logic [OFS_W:0]     pk_sum;
  logic [BYTES_W-1:0] bytes_nxt;
  logic [DW:0]        row_inc, plane_inc, batch_inc;
  logic               row_end, plane_end, batch_end;
  logic               last;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      ldw_r   <= DW'(1);
      ldh_r   <= DW'(1);
      ldc_r   <= DW'(1);
      tw_r    <= DW'(1);
      th_r    <= DW'(1);
      tc_r    <= DW'(1);
      tn_r    <= DW'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_START:         start_r <= cfg_wdata[START_W-1:0];
        REG_ROW_STRIDE:    ldw_r   <= cfg_wdata[DW-1:0];
        REG_PLANE_ROWS:    ldh_r   <= cfg_wdata[DW-1:0];
        REG_BATCH_PLANES:  ldc_r   <= cfg_wdata[DW-1:0];
        REG_TILE_WIDTH:    tw_r    <= cfg_wdata[DW-1:0];
        REG_TILE_HEIGHT:   th_r    <= cfg_wdata[DW-1:0];
        REG_TILE_CHANNELS: tc_r    <= cfg_wdata[DW-1:0];
        REG_TILE_BATCHES:  tn_r    <= cfg_wdata[DW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START:         cfg_rdata = APB_DW'(start_r);
      REG_ROW_STRIDE:    cfg_rdata = APB_DW'(ldw_r);
      REG_PLANE_ROWS:    cfg_rdata = APB_DW'(ldh_r);
      REG_BATCH_PLANES:  cfg_rdata = APB_DW'(ldc_r);
      REG_TILE_WIDTH:    cfg_rdata = APB_DW'(tw_r);
      REG_TILE_HEIGHT:   cfg_rdata = APB_DW'(th_r);
      REG_TILE_CHANNELS: cfg_rdata = APB_DW'(tc_r);
      REG_TILE_BATCHES:  cfg_rdata = APB_DW'(tn_r);
    endcase
  end

  always_comb begin
    merge_calc = MERGE_NONE;
    if (tw_r == ldw_r) begin
      merge_calc = MERGE_ROWS;
      if (th_r == ldh_r) begin
        merge_calc = MERGE_PLANES;
        if (tc_r == ldc_r) begin
          merge_calc = MERGE_BATCHES;
        end
      end
    end
  end

  // operand select for the offset chain and the length chain
  always_comb begin
    unique case (cmd.step)
      STEP_OUTER: begin
        off_a   = SAT_W'(batch_r);
        off_b   = ldc_r;
        off_add = SAT_W'(plane_r);
        len_a   = SAT_W'(tw_r);
        len_b   = (merge_r >= MERGE_ROWS) ? th_r : DW'(1);
      end
      STEP_MIDDLE: begin
        off_a   = off_res;
        off_b   = ldh_r;
        off_add = SAT_W'(row_r);
        len_a   = len_res;
        len_b   = (merge_r >= MERGE_PLANES) ? tc_r : DW'(1);
      end
      STEP_INNER: begin
        off_a   = off_res;
        off_b   = ldw_r;
        off_add = SAT_W'(start_r);
        len_a   = len_res;
        len_b   = (merge_r == MERGE_BATCHES) ? tn_r : DW'(1);
      end
      default: begin
        off_a   = '0;
        off_b   = '0;
        off_add = '0;
        len_a   = '0;
        len_b   = '0;
      end
    endcase
  end

  stdg_mac #(.DIM_W(DW)) u_off_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cmd.mul_go),
    .a      (off_a),
    .b      (off_b),
    .addend (off_add),
    .result (off_res)
  );

  stdg_mac #(.DIM_W(DW)) u_len_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (cmd.mul_go),
    .a      (len_a),
    .b      (len_b),
    .addend ('0),
    .result (len_res)
  );

  always_comb begin
    soff_ovf  = off_res[OFS_W];
    soff      = soff_ovf ? '1 : off_res[OFS_W-1:0];
    len_ovf   = len_res[OFS_W];
    len       = len_ovf ? '1 : len_res[OFS_W-1:0];
    pk_sum    = {1'b0, packed_r} + {1'b0, len};
    pk_ovf    = pk_sum[OFS_W] & (|pk_sum[OFS_W-1:0]);
    bytes_nxt = bytes_r + BYTES_W'(len) * BYTES_W'(ELEMENT_BYTES);

    row_inc   = {1'b0, row_r} + (DW+1)'(1);
    plane_inc = {1'b0, plane_r} + (DW+1)'(1);
    batch_inc = {1'b0, batch_r} + (DW+1)'(1);
    row_end   = row_inc >= {1'b0, th_r};
    plane_end = plane_inc >= {1'b0, tc_r};
    batch_end = batch_inc >= {1'b0, tn_r};

    last = (merge_r >= MERGE_ROWS || row_end)
        && (merge_r >= MERGE_PLANES || plane_end)
        && (merge_r == MERGE_BATCHES || batch_end);
  end

  // odometer advance, innermost live dimension first
  always_comb begin
    logic carry;
    carry     = 1'b1;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    batch_nxt = batch_r;
    if (merge_r == MERGE_NONE) begin
      row_nxt = row_end ? '0 : row_inc[DW-1:0];
      carry   = row_end;
    end
    if (merge_r <= MERGE_ROWS && carry) begin
      plane_nxt = plane_end ? '0 : plane_inc[DW-1:0];
      carry     = plane_end;
    end
    if (merge_r <= MERGE_PLANES && carry) begin
      batch_nxt = batch_end ? '0 : batch_inc[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      plane_r  <= '0;
      batch_r  <= '0;
      packed_r <= '0;
      bytes_r  <= '0;
      merge_r  <= MERGE_NONE;
    end else if (cmd.accept && cmd.restart) begin
      row_r    <= '0;
      plane_r  <= '0;
      batch_r  <= '0;
      packed_r <= '0;
      bytes_r  <= '0;
      merge_r  <= merge_calc;
    end else if (cmd.emit) begin
      packed_r <= pk_sum[OFS_W-1:0];
      bytes_r  <= bytes_nxt;
      if (!last) begin
        row_r   <= row_nxt;
        plane_r <= plane_nxt;
        batch_r <= batch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dir_r <= in_direction;
    end
    if (cmd.emit) begin
      out_r.strided_offset <= soff;
      out_r.packed_offset  <= packed_r;
      out_r.chunk_length   <= len;
      out_r.bytes_so_far   <= bytes_nxt;
      out_r.direction_tag  <= dir_r;
      out_r.last_chunk     <= last;
      out_r.overflow       <= soff_ovf | len_ovf | pk_ovf;
    end
  end

  always_comb begin
    status.tile_ok = (|tw_r) & (|th_r) & (|tc_r) & (|tn_r);
    status.last    = last;
  end

  assign out_word = out_r;

endmodule

// ===== design/stdg_ctrl.sv =====
module stdg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_restart,
  output logic                   out_valid,
  input  logic                   out_ready,
  output stdg_pkg::stdg_cmd_t    cmd,
  input  stdg_pkg::stdg_status_t status
);
  import stdg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACTIVE,
    ST_CALC,
    ST_EMIT
  } state_t;

  state_t     state_r, state_nxt;
  stdg_step_t step_r, step_nxt;
  logic       half_r, half_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, emit;

  always_comb begin
    in_ready = (state_r == ST_IDLE) || (state_r == ST_ACTIVE);
    accept   = in_valid && in_ready;
    emit     = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

    cmd.accept  = accept;
    cmd.restart = in_restart;
    cmd.mul_go  = (state_r == ST_CALC) && !half_r;
    cmd.step    = step_r;
    cmd.emit    = emit;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    half_nxt  = half_r;
    unique case (state_r)
      ST_IDLE, ST_ACTIVE: begin
        if (accept) begin
          step_nxt = STEP_OUTER;
          half_nxt = 1'b0;
          if (in_restart) begin
            state_nxt = status.tile_ok ? ST_CALC : ST_IDLE;
          end else begin
            state_nxt = (state_r == ST_ACTIVE) ? ST_CALC : ST_IDLE;
          end
        end
      end
      ST_CALC: begin
        half_nxt = !half_r;
        if (half_r) begin
          unique case (step_r)
            STEP_OUTER:  step_nxt = STEP_MIDDLE;
            STEP_MIDDLE: step_nxt = STEP_INNER;
            STEP_INNER:  state_nxt = ST_EMIT;
            default:     step_nxt = STEP_OUTER;
          endcase
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_nxt = status.last ? ST_IDLE : ST_ACTIVE;
        end
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_OUTER;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/strided_tile_descriptor_gen_core.sv =====
// Copy descriptor generator for one 4-D NCHW tile inside a larger strided tensor.
// Program the start index, leading dimensions and tile dimensions over the APB port
// while the block is idle, then send words: restart=1 begins a tile at its first
// chunk, restart=0 asks for the next chunk. Each word yields one descriptor while a
// tile is active and none otherwise. For a word that yields a descriptor, the offset
// and the length are each built by three dependent saturating multiply-add steps
// in a two-stage split multiplier, and the output register is then updated once
// the result side can take it. The next word is taken the cycle after that update,
// so the block takes no new word until the current descriptor is in the output
// register. Merging of contiguous rows, planes or batches is decided at restart.
module strided_tile_descriptor_gen_core #(
  parameter int ELEMENT_BYTES = stdg_pkg::ELEMENT_BYTES_DEF,
  parameter int DIM_WIDTH     = stdg_pkg::DIM_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  stdg_pkg::stdg_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output stdg_pkg::stdg_out_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stdg_pkg::APB_AW-1:0] paddr,
  input  logic [stdg_pkg::APB_DW-1:0] pwdata,
  output logic [stdg_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import stdg_pkg::*;

  stdg_cmd_t           cmd;
  stdg_status_t        status;
  logic                cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = paddr[APB_AW-1:2];

  stdg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_data.restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .status     (status)
  );

  stdg_datapath #(
    .ELEMENT_BYTES (ELEMENT_BYTES),
    .DIM_WIDTH     (DIM_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (pwdata),
    .cfg_rdata    (prdata),
    .in_direction (in_data.direction),
    .cmd          (cmd),
    .status       (status),
    .out_word     (out_data)
  );

endmodule

// ===== bench/tb_strided_tile_descriptor_gen_core.sv =====
`timescale 1ns / 100ps

module tb_strided_tile_descriptor_gen_core;
  import stdg_pkg::*;

  typedef bit [63:0] u64_t;

  localparam u64_t MASK48   = 64'h0000_FFFF_FFFF_FFFF;
  localparam u64_t MASK52   = 64'h000F_FFFF_FFFF_FFFF;
  localparam u64_t DIM_MASK = 64'h0000_0000_0000_FFFF;
  localparam u64_t CLIP_TOP = 64'h4000_0000_0000_0000;
  localparam int DRAIN_CYCLES = 20;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  stdg_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  stdg_out_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  strided_tile_descriptor_gen_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // register copy and tile walk state
  u64_t       reg_shadow[8];
  u64_t       row_cnt, plane_cnt, batch_cnt, packed_pos, byte_sum;
  logic [1:0] tile_merge;
  bit         tile_active;

  stdg_in_t   word_q[$];
  stdg_out_t  descriptor_q[$];
  stdg_out_t  want;

  int         words_sent = 0;
  int         words_taken = 0;
  int         restarts_sent = 0;
  int         reg_writes = 0;
  int         results_seen = 0;
  int         ovf_seen = 0;
  int         ends_seen = 0;
  int         errors = 0;
  int         cyc = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;
  wire        calm = (cyc >= 1500) && (cyc < 3000);

  initial begin
    reg_shadow[REG_START] = 0;
    for (int i = 1; i < 8; i++) reg_shadow[i] = 1;
    row_cnt = 0;
    plane_cnt = 0;
    batch_cnt = 0;
    packed_pos = 0;
    byte_sum = 0;
    tile_merge = MERGE_NONE;
    tile_active = 1'b0;
  end

  function automatic u64_t mul_clip(u64_t a, u64_t b);
    u64_t r;
    if (a != 0 && b > CLIP_TOP / a) return CLIP_TOP;
    r = a * b;
    return (r > CLIP_TOP) ? CLIP_TOP : r;
  endfunction

  function automatic u64_t add_clip(u64_t a, u64_t b);
    u64_t r;
    r = a + b;
    return (r > CLIP_TOP) ? CLIP_TOP : r;
  endfunction

  function automatic bit next_descriptor(stdg_in_t w, output stdg_out_t d);
    u64_t start, ldw, ldh, ldc, tw, th, tc, tn, idx, soff, len, nb;
    bit ovf, last, carry;
    start = reg_shadow[REG_START];
    ldw = reg_shadow[REG_ROW_STRIDE];
    ldh = reg_shadow[REG_PLANE_ROWS];
    ldc = reg_shadow[REG_BATCH_PLANES];
    tw = reg_shadow[REG_TILE_WIDTH];
    th = reg_shadow[REG_TILE_HEIGHT];
    tc = reg_shadow[REG_TILE_CHANNELS];
    tn = reg_shadow[REG_TILE_BATCHES];
    d = '0;
    if (w.restart) begin
      tile_merge = MERGE_NONE;
      if (tw == ldw) begin
        tile_merge = MERGE_ROWS;
        if (th == ldh) begin
          tile_merge = MERGE_PLANES;
          if (tc == ldc) tile_merge = MERGE_BATCHES;
        end
      end
      row_cnt = 0;
      plane_cnt = 0;
      batch_cnt = 0;
      packed_pos = 0;
      byte_sum = 0;
      tile_active = (tw != 0) && (th != 0) && (tc != 0) && (tn != 0);
    end
    if (!tile_active) return 1'b0;

    idx = add_clip((batch_cnt == 0) ? 64'd0 : mul_clip(ldc, batch_cnt), plane_cnt);
    idx = add_clip(mul_clip(ldh, idx), row_cnt);
    soff = add_clip(start, mul_clip(ldw, idx));

    len = tw;
    if (tile_merge >= MERGE_ROWS) len = mul_clip(len, th);
    if (tile_merge >= MERGE_PLANES) len = mul_clip(len, tc);
    if (tile_merge >= MERGE_BATCHES) len = mul_clip(len, tn);

    ovf = 1'b0;
    if (soff > MASK48) begin
      soff = MASK48;
      ovf = 1'b1;
    end
    if (len > MASK48) begin
      len = MASK48;
      ovf = 1'b1;
    end
    if (packed_pos + len > MASK48 + 1) ovf = 1'b1;

    last = (tile_merge > MERGE_NONE || row_cnt + 1 >= th) &&
           (tile_merge > MERGE_ROWS || plane_cnt + 1 >= tc) &&
           (tile_merge > MERGE_PLANES || batch_cnt + 1 >= tn);

    nb = (byte_sum + len * ELEMENT_BYTES_DEF) & MASK52;

    d.strided_offset = soff[OFS_W-1:0];
    d.packed_offset  = packed_pos[OFS_W-1:0];
    d.chunk_length   = len[OFS_W-1:0];
    d.bytes_so_far   = nb[BYTES_W-1:0];
    d.direction_tag  = w.direction;
    d.last_chunk     = last;
    d.overflow       = ovf;

    packed_pos = (packed_pos + len) & MASK48;
    byte_sum = nb;

    if (last) begin
      tile_active = 1'b0;
    end else begin
      carry = 1'b1;
      if (tile_merge == MERGE_NONE && carry) begin
        if (row_cnt + 1 < th) begin
          row_cnt++;
          carry = 1'b0;
        end else row_cnt = 0;
      end
      if (tile_merge <= MERGE_ROWS && carry) begin
        if (plane_cnt + 1 < tc) begin
          plane_cnt++;
          carry = 1'b0;
        end else plane_cnt = 0;
      end
      if (tile_merge <= MERGE_PLANES && carry) begin
        if (batch_cnt + 1 < tn) batch_cnt++;
        else batch_cnt = 0;
      end
      row_cnt &= DIM_MASK;
      plane_cnt &= DIM_MASK;
      batch_cnt &= DIM_MASK;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) cyc <= cyc + 1;

  // word driver
  always @(posedge clk) begin
    stdg_out_t d;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (next_descriptor(in_data, d)) descriptor_q.push_back(d);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
          in_valid <= 1'b1;
          in_data <= word_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // descriptor receiver, with one long hold-off while words are still queued
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 60 && word_q.size() > 4) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  task automatic flag(string msg);
    errors++;
    if (errors <= 10) $display("%0t ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) flag($sformatf("%s expected %0h, got %0h", name, exp_v, got_v));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (descriptor_q.size() == 0) begin
        flag($sformatf("descriptor with nothing pending: %p", out_data));
      end else begin
        want = descriptor_q.pop_front();
        if (want.overflow) ovf_seen++;
        if (want.last_chunk) ends_seen++;
        check_field("strided_offset", 64'(want.strided_offset),
                    64'(out_data.strided_offset));
        check_field("packed_offset", 64'(want.packed_offset),
                    64'(out_data.packed_offset));
        check_field("chunk_length", 64'(want.chunk_length),
                    64'(out_data.chunk_length));
        check_field("bytes_so_far", 64'(want.bytes_so_far),
                    64'(out_data.bytes_so_far));
        check_field("direction_tag", 64'(want.direction_tag),
                    64'(out_data.direction_tag));
        check_field("last_chunk", 64'(want.last_chunk), 64'(out_data.last_chunk));
        check_field("overflow", 64'(want.overflow), 64'(out_data.overflow));
      end
    end
  end

  task automatic send(bit rs, bit dir);
    stdg_in_t w;
    w.restart = rs;
    w.direction = dir;
    word_q.push_back(w);
    words_sent++;
    if (rs) restarts_sent++;
  endtask

  task automatic drain();
    while (words_taken != words_sent || descriptor_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    reg_shadow[idx] = (idx == REG_START) ? (val & 32'h7FFF_FFFF) : (val & DIM_MASK);
    reg_writes++;
  endtask

  task automatic load_tile(logic [31:0] start, logic [31:0] ldw, logic [31:0] ldh,
                           logic [31:0] ldc, logic [31:0] tw, logic [31:0] th,
                           logic [31:0] tc, logic [31:0] tn);
    write_reg(REG_START, start);
    write_reg(REG_ROW_STRIDE, ldw);
    write_reg(REG_PLANE_ROWS, ldh);
    write_reg(REG_BATCH_PLANES, ldc);
    write_reg(REG_TILE_WIDTH, tw);
    write_reg(REG_TILE_HEIGHT, th);
    write_reg(REG_TILE_CHANNELS, tc);
    write_reg(REG_TILE_BATCHES, tn);
  endtask

  function automatic logic [15:0] rand_small();
    if ($urandom_range(99) < 5) return 16'd0;
    return 16'($urandom_range(1, 4));
  endfunction

  function automatic logic [15:0] rand_big();
    case ($urandom_range(9))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  initial begin : stim
    logic [15:0] tw, th, tc, tn, ldw, ldh, ldc;
    logic [30:0] start;
    u64_t chunks;
    int base, n, kind;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // advance while idle, then a single-chunk tile at reset settings
    send(1'b0, 1'b0);
    send(1'b1, 1'b1);
    drain();

    // row-by-row tile, config changed mid-tile, then restart while busy
    load_tile(32'hFFFF_FFFF, 10, 5, 3, 4, 2, 2, 2);
    send(1'b1, 1'b0);
    repeat (3) send(1'b0, 1'b1);
    drain();
    write_reg(REG_TILE_HEIGHT, 1);
    repeat (2) send(1'b0, 1'b0);
    send(1'b1, 1'b1);
    repeat (2) send(1'b0, 1'b0);
    drain();

    // strided offset past 48 bits on the third batch, then advance while idle
    load_tile(0, 32'hFFFF, 32'hFFFF, 32'hFFFF, 1, 1, 1, 3);
    send(1'b1, 1'b0);
    repeat (3) send(1'b0, 1'b1);
    drain();

    // whole tile merged, length saturates
    load_tile(0, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF);
    send(1'b1, 1'b1);
    drain();

    // planes merged, packed end runs past 48 bits on the second batch
    load_tile(32'h7FFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFE, 32'hFFFF, 32'hFFFF,
              32'hFFFF, 2);
    send(1'b1, 1'b0);
    send(1'b0, 1'b0);
    drain();

    // zero tile batches: restart issues nothing
    load_tile(5, 3, 4, 2, 3, 4, 2, 0);
    send(1'b1, 1'b1);
    send(1'b0, 1'b1);
    drain();

    // full rows merged
    load_tile(100, 7, 8, 2, 7, 3, 2, 1);
    send(1'b1, 1'b0);
    send(1'b0, 1'b1);
    drain();

    base = words_sent;
    while (words_sent - base < 400) begin
      case ($urandom_range(3))
        0: start = '0;
        1: start = '1;
        default: start = 31'($urandom());
      endcase
      tw = rand_big();
      ldw = $urandom_range(1) ? tw : rand_big();
      th = (ldw == tw) ? rand_big() : rand_small();
      ldh = $urandom_range(1) ? th : rand_big();
      tc = (ldw == tw && ldh == th) ? rand_big() : rand_small();
      ldc = $urandom_range(1) ? tc : rand_big();
      tn = (ldw == tw && ldh == th && ldc == tc) ? rand_big() : rand_small();
      load_tile({1'($urandom_range(1)), start}, {16'($urandom()), ldw},
                {16'($urandom()), ldh}, {16'($urandom()), ldc}, {16'($urandom()), tw},
                {16'($urandom()), th}, {16'($urandom()), tc}, {16'($urandom()), tn});

      repeat ($urandom_range(1, 4)) begin
        chunks = 0;
        if (reg_shadow[REG_TILE_WIDTH] != 0 && reg_shadow[REG_TILE_HEIGHT] != 0 &&
            reg_shadow[REG_TILE_CHANNELS] != 0 && reg_shadow[REG_TILE_BATCHES] != 0) begin
          chunks = reg_shadow[REG_TILE_BATCHES];
          if (reg_shadow[REG_TILE_WIDTH] != reg_shadow[REG_ROW_STRIDE])
            chunks = chunks * reg_shadow[REG_TILE_HEIGHT] * reg_shadow[REG_TILE_CHANNELS];
          else if (reg_shadow[REG_TILE_HEIGHT] != reg_shadow[REG_PLANE_ROWS])
            chunks = chunks * reg_shadow[REG_TILE_CHANNELS];
          else if (reg_shadow[REG_TILE_CHANNELS] == reg_shadow[REG_BATCH_PLANES])
            chunks = 1;
        end
        n = (chunks > 40) ? 40 : int'(chunks);
        kind = $urandom_range(99);
        if (kind < 12) begin
          repeat ($urandom_range(1, 3)) send(1'b0, 1'($urandom_range(1)));
        end else begin
          // tile from its restart, some cut short, later abandoned or advanced after a register write
          if (kind >= 75 && n > 1) n = $urandom_range(1, n - 1);
          send(1'b1, 1'($urandom_range(1)));
          for (int k = 1; k < n; k++) send(1'b0, 1'($urandom_range(1)));
          if (kind >= 90) begin
            drain();
            write_reg(REG_IDX_W'($urandom_range(7)),
                      32'($urandom_range(1) ? rand_big() : rand_small()));
            repeat ($urandom_range(1, 6)) send(1'b0, 1'($urandom_range(1)));
          end
        end
      end
      drain();
    end

    drain();
    $display("Sent %0d words (%0d restarts) across %0d register writes",
             words_sent, restarts_sent, reg_writes);
    $display("Checked %0d descriptors: %0d tile ends, %0d with overflow",
             results_seen, ends_seen, ovf_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout after %0d cycles", cyc);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
design/stdg_pkg.sv
design/stdg_mac.sv
design/stdg_datapath.sv
design/stdg_ctrl.sv
design/strided_tile_descriptor_gen_core.sv
bench/tb_strided_tile_descriptor_gen_core.sv
